### design/mcc_pkg.sv
// Shared constants, types and control struct for the multiset combination counter.
// No dependencies; every other file of the block imports this package.
package mcc_pkg;

	// Largest target size that the coefficient table covers.
	localparam int MAX_TARGET = 64;
	localparam int DEPTH      = MAX_TARGET + 1;
	localparam int IDX_W      = $clog2(DEPTH);

	// Fixed field widths.
	localparam int MULT_W = 16;
	localparam int TGT_W  = 7;
	localparam int CNT_W  = 63;

	// Exact window sum of up to DEPTH clamped entries.
	localparam int ACC_W = CNT_W + $clog2(DEPTH);

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	// Control from the sequencer to the table datapath.
	typedef struct packed {
		logic             rd_en;     // issue a table read
		logic             rd_bank;   // bank holding the old table
		logic [IDX_W-1:0] rd_a_idx;  // entry entering the window
		logic [IDX_W-1:0] rd_b_idx;  // entry leaving the window
		logic             wr_en;     // write one new entry (read data valid)
		logic             wr_bank;   // bank receiving the new table
		logic [IDX_W-1:0] wr_idx;
		logic             wr_init;   // first element: write the seed value
		logic             init_one;  // seed value is one
		logic             b_use;     // leaving entry exists
		logic             clr_win;   // clear the window sum
		logic             clr_ovf;   // clear the overflow flag
	} mcc_ctrl_t;

endpackage

### design/mcc_in_if.sv
// Request channel carrying one multiplicity per distinct element.
// Depends on mcc_pkg for the field widths.
interface mcc_in_if;
	import mcc_pkg::*;

	logic              valid;
	logic              ready;
	logic [MULT_W-1:0] multiplicity;
	logic              last_element;

	modport source (output valid, output multiplicity, output last_element, input ready);
	modport sink   (input valid, input multiplicity, input last_element, output ready);

endinterface

### design/mcc_out_if.sv
// Result channel carrying the combination count and saturation flag.
// Depends on mcc_pkg for the field widths.
interface mcc_out_if;
	import mcc_pkg::*;

	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] combination_count;
	logic             saturated;

	modport source (output valid, output combination_count, output saturated, input ready);
	modport sink   (input valid, input combination_count, input saturated, output ready);

endinterface

### design/mcc_table.sv
// Coefficient table (two banks in one memory) and the shared window-sum unit.
// Depends on mcc_pkg for widths and the control struct.
module mcc_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mcc_pkg::mcc_ctrl_t          ctrl,
	output logic [mcc_pkg::CNT_W-1:0]   rd_data,
	output logic                        ovf
);
	import mcc_pkg::*;

	localparam int MEM_DEPTH = 2 * DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	logic [CNT_W-1:0] mem [MEM_DEPTH];

	logic [CNT_W-1:0] rd_a_s1;
	logic [CNT_W-1:0] rd_b_s1;
	logic [ACC_W-1:0] win_q;
	logic             ovf_q;
	logic [ACC_W-1:0] win_next;
	logic             win_over;
	logic [CNT_W-1:0] new_entry;
	logic [CNT_W-1:0] wr_data;

	function automatic logic [ADDR_W-1:0] mem_addr(input logic bank,
	                                              input logic [IDX_W-1:0] idx);
		logic [ADDR_W-1:0] base;
		base = bank ? ADDR_W'(DEPTH) : '0;
		return base + ADDR_W'(idx);
	endfunction

	// Slide the window: add the entering entry, drop the leaving one.
	always_comb begin
		win_next = win_q + ACC_W'(rd_a_s1) - (ctrl.b_use ? ACC_W'(rd_b_s1) : '0);
		win_over = |win_next[ACC_W-1:CNT_W];
		new_entry = win_over ? COUNT_MAX : win_next[CNT_W-1:0];
		wr_data = ctrl.wr_init ? CNT_W'(ctrl.init_one) : new_entry;
	end

	// Table memory: one write, two registered reads.
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[mem_addr(ctrl.wr_bank, ctrl.wr_idx)] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_a_s1 <= mem[mem_addr(ctrl.rd_bank, ctrl.rd_a_idx)];
			rd_b_s1 <= mem[mem_addr(ctrl.rd_bank, ctrl.rd_b_idx)];
		end
	end

	// Hold the running window sum.
	always_ff @(posedge clk) begin
		if (ctrl.clr_win) begin
			win_q <= '0;
		end else if (ctrl.wr_en && !ctrl.wr_init) begin
			win_q <= win_next;
		end
	end

	// Track any clamp within the current multiset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (ctrl.clr_ovf) begin
			ovf_q <= 1'b0;
		end else if (ctrl.wr_en && !ctrl.wr_init && win_over) begin
			ovf_q <= 1'b1;
		end
	end

	assign rd_data = rd_a_s1;
	assign ovf     = ovf_q;

endmodule

### design/mcc_seq.sv
// Sequencer: walks the table one entry a cycle per element and fetches the result.
// Depends on mcc_pkg for widths and the control struct.
module mcc_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_fire,
	input  logic [mcc_pkg::MULT_W-1:0]  multiplicity,
	input  logic                        last_element,
	input  logic [mcc_pkg::TGT_W-1:0]   target_size,
	input  logic                        out_free,
	output logic                        in_ready,
	output logic                        out_load,
	output mcc_pkg::mcc_ctrl_t          ctrl
);
	import mcc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SWEEP = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_READ  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  k_q;
	logic [MULT_W-1:0] mult_q;
	logic              last_q;
	logic              first_q;
	logic              expect_first_q;
	logic              cur_bank_q;

	logic              wr_en_s1;
	logic [IDX_W-1:0]  wr_idx_s1;
	logic              init_one_s1;
	logic              b_use_s1;

	logic              b_use;
	logic [IDX_W-1:0]  b_idx;
	logic [IDX_W-1:0]  tgt_idx;
	logic              k_end;

	// Window edge and clamped target index.
	always_comb begin
		b_use = MULT_W'(k_q) > mult_q;
		b_idx = b_use ? (k_q - mult_q[IDX_W-1:0] - IDX_W'(1)) : '0;
		if (int'(target_size) > MAX_TARGET) begin
			tgt_idx = IDX_W'(MAX_TARGET);
		end else begin
			tgt_idx = IDX_W'(target_size);
		end
		k_end = k_q == IDX_W'(MAX_TARGET);
	end

	// Drive datapath control.
	always_comb begin
		ctrl          = '0;
		ctrl.rd_en    = (state_q == ST_SWEEP) || (state_q == ST_READ);
		ctrl.rd_bank  = cur_bank_q;
		ctrl.rd_a_idx = (state_q == ST_READ) ? tgt_idx : k_q;
		ctrl.rd_b_idx = b_idx;
		ctrl.wr_en    = wr_en_s1;
		ctrl.wr_bank  = ~cur_bank_q;
		ctrl.wr_idx   = wr_idx_s1;
		ctrl.wr_init  = first_q;
		ctrl.init_one = init_one_s1;
		ctrl.b_use    = b_use_s1;
		ctrl.clr_win  = in_fire;
		ctrl.clr_ovf  = in_fire && expect_first_q;
	end

	assign in_ready = state_q == ST_IDLE;
	assign out_load = (state_q == ST_OUT) && out_free;

	// Capture the request.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mult_q <= multiplicity;
			last_q <= last_element;
		end
	end

	// Delay write control to line up with the registered read data.
	always_ff @(posedge clk) begin
		wr_idx_s1   <= k_q;
		init_one_s1 <= MULT_W'(k_q) <= mult_q;
		b_use_s1    <= b_use;
	end

	// Advance the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			k_q            <= '0;
			first_q        <= 1'b0;
			expect_first_q <= 1'b1;
			cur_bank_q     <= 1'b0;
			wr_en_s1       <= 1'b0;
		end else begin
			wr_en_s1 <= state_q == ST_SWEEP;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						k_q     <= '0;
						first_q <= expect_first_q;
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					k_q <= k_q + IDX_W'(1);
					if (k_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					cur_bank_q     <= ~cur_bank_q;
					expect_first_q <= last_q;
					state_q        <= last_q ? ST_READ : ST_IDLE;
				end
				ST_READ: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// New table never lands in the bank being read.
	a_bank_split: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.wr_en && ctrl.rd_en) |-> (ctrl.wr_bank != ctrl.rd_bank))
		else $error("table write and read hit the same bank");

	// Every sweep writes exactly through the last entry before draining.
	a_drain_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (wr_en_s1 && wr_idx_s1 == IDX_W'(MAX_TARGET)))
		else $error("sweep ended before the last entry");

	// A last element always leads to a result fetch.
	a_last_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && last_q) |=> (state_q == ST_READ))
		else $error("last element did not fetch a result");

	// No new request while a sweep is writing.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en_s1 |-> !in_fire)
		else $error("request accepted during a sweep");

endmodule

### design/multiset_combination_count_core.sv
// Top level of the multiset combination counter: config register, output register, wiring.
// Depends on mcc_pkg, mcc_in_if, mcc_out_if, mcc_table and mcc_seq.
//
// Each request carries the multiplicity of one distinct element; the request
// marked last_element returns the number of target_size combinations of the
// multiset, clamped at 2^63-1, with saturated set if any coefficient clamped
// along the way. Every request walks the whole coefficient table of
// MAX_TARGET+1 entries through one shared window-sum adder, one entry per
// cycle, then drains the last table write before ready returns. A last
// request then fetches the selected entry from the table memory and loads
// it into the output register, and the next request is taken after that,
// or later while the output register still holds an earlier result that
// has not been taken. One request is in flight at a time; a finished result
// sits in an output register so the next request can be taken while it
// waits. target_size above MAX_TARGET selects entry MAX_TARGET, and its
// value at the last request is the one used.
// Write target_size only while idle.
module multiset_combination_count_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [mcc_pkg::TGT_W-1:0]  cfg_wdata,
	mcc_in_if.sink                     item_ch,
	mcc_out_if.source                  result_ch
);
	import mcc_pkg::*;

	logic [TGT_W-1:0] target_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] count_q;
	logic             sat_q;

	logic             in_fire;
	logic             out_free;
	logic             out_load;
	logic [CNT_W-1:0] rd_data;
	logic             ovf;
	mcc_ctrl_t        ctrl;

	assign in_fire  = item_ch.valid && item_ch.ready;
	assign out_free = !out_valid_q || result_ch.ready;

	// Hold the target size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_wen) begin
			target_q <= cfg_wdata;
		end
	end

	mcc_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_fire      (in_fire),
		.multiplicity (item_ch.multiplicity),
		.last_element (item_ch.last_element),
		.target_size  (target_q),
		.out_free     (out_free),
		.in_ready     (item_ch.ready),
		.out_load     (out_load),
		.ctrl         (ctrl)
	);

	mcc_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.rd_data (rd_data),
		.ovf     (ovf)
	);

	// Output register: load a result, drop it once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			count_q <= rd_data;
			sat_q   <= ovf;
		end
	end

	assign result_ch.valid             = out_valid_q;
	assign result_ch.combination_count = count_q;
	assign result_ch.saturated         = sat_q;

endmodule

### bench/multiset_combination_count_core_tb.sv
// Self-checking bench for multiset_combination_count_core: directed and random multisets.
// Depends on mcc_pkg, mcc_in_if and mcc_out_if; a tracker class predicts each count.
import mcc_pkg::*;

typedef struct packed {
	logic [CNT_W-1:0] count;
	logic             sat;
} comb_result_t;

// Coefficient table mirror plus the queue of counts owed by last-element requests.
class comb_count_tracker;
	logic [CNT_W-1:0] coef [DEPTH];
	bit               at_first;
	bit               ovf;
	logic [TGT_W-1:0] target;
	comb_result_t     owed [$];
	int               errors;

	function new();
		at_first = 1;
		ovf      = 0;
		target   = '0;
		errors   = 0;
	endfunction

	function void set_target(logic [TGT_W-1:0] v);
		target = v;
	endfunction

	function int pending();
		return owed.size();
	endfunction

	// Fold one multiplicity into the table; owe a count on the last element.
	function void note_request(logic [MULT_W-1:0] mult, logic last);
		int             m;
		int             k;
		int             j;
		int             lo;
		int             t;
		logic [CNT_W:0] acc;
		comb_result_t   r;
		m = int'(mult);
		if (at_first) begin
			ovf = 0;
			for (k = 0; k < DEPTH; k++)
				coef[k] = CNT_W'(k <= m);
			at_first = 0;
		end else begin
			// Walk downward so each entry reads only old lower entries.
			for (k = MAX_TARGET; k >= 0; k--) begin
				lo  = (k > m) ? k - m : 0;
				acc = '0;
				for (j = lo; j <= k; j++) begin
					acc = acc + {1'b0, coef[j]};
					if (acc > {1'b0, COUNT_MAX}) begin
						acc = {1'b0, COUNT_MAX};
						ovf = 1;
					end
				end
				coef[k] = acc[CNT_W-1:0];
			end
		end
		if (last) begin
			t = int'(target);
			if (t > MAX_TARGET)
				t = MAX_TARGET;
			r.count  = coef[t];
			r.sat    = ovf;
			owed.insert(owed.size(), r);
			at_first = 1;
		end
	endfunction

	// Compare one result with the oldest owed count.
	function void check_result(logic [CNT_W-1:0] count, logic sat);
		comb_result_t r;
		if (owed.size() == 0) begin
			$error("unrequested result: combination_count %0d saturated %0b", count, sat);
			errors++;
			return;
		end
		r = owed.pop_front();
		if (count !== r.count) begin
			$error("combination_count: expected %0d, actual %0d", r.count, count);
			errors++;
		end
		if (sat !== r.sat) begin
			$error("saturated: expected %0b, actual %0b", r.sat, sat);
			errors++;
		end
	endfunction
endclass

module multiset_combination_count_core_tb;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE      = MAX_TARGET + 16;
	localparam int PHASE_ITEMS = 52;

	logic             clk;
	logic             arst_n;
	logic             cfg_wen;
	logic [TGT_W-1:0] cfg_wdata;
	int               tx_pct;
	int               rx_pct;
	int               cycle_count;

	comb_count_tracker tracker;

	mcc_in_if  item_ch ();
	mcc_out_if result_ch ();

	multiset_combination_count_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.item_ch   (item_ch),
		.result_ch (result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Offer one request after a random gap (none when tx_pct is zero) and hold it until accepted.
	task automatic send_request(logic [MULT_W-1:0] mult, logic last);
		int gap;
		gap = 0;
		@(negedge clk);
		if (tx_pct > 0) begin
			while ($urandom_range(99) < tx_pct)
				gap++;
			if ($urandom_range(7) == 0)
				gap += $urandom_range(1, 75);
		end
		if (gap > 0) begin
			item_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid        = 1'b1;
		item_ch.multiplicity = mult;
		item_ch.last_element = last;
		do
			@(posedge clk);
		while (!item_ch.ready);
		tracker.note_request(mult, last);
	endtask

	// Drop the request line and hold until every owed count has come back.
	task automatic drain_results();
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (tracker.pending() > 0)
			@(posedge clk);
	endtask

	// Write target_size once the block has gone quiet.
	task automatic write_target(logic [TGT_W-1:0] v);
		drain_results();
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_wen   = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_wen   = 1'b0;
		tracker.set_target(v);
	endtask

	// Result side: check on handshake, pick the next ready at the falling edge.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready)
				tracker.check_result(result_ch.combination_count, result_ch.saturated);
			@(negedge clk);
			result_ch.ready = ($urandom_range(99) >= rx_pct);
		end
	end

	// Watchdog.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("multiset_combination_count_core regression: fail");
		$finish;
	end

	initial begin
		int               phase;
		int               phase_items;
		int               len;
		int               mix;
		int               n;
		bit               paused;
		logic [MULT_W-1:0] m;
		arst_n               = 1'b0;
		cfg_wen              = 1'b0;
		cfg_wdata            = '0;
		item_ch.valid        = 1'b0;
		item_ch.multiplicity = '0;
		item_ch.last_element = 1'b0;
		tx_pct               = 22;
		rx_pct               = 53;
		tracker              = new();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Zero target: always one.
		write_target(7'd0);
		send_request(16'd0, 1'b1);
		send_request(16'hFFFF, 1'b1);
		send_request(16'd3, 1'b0);
		send_request(16'd7, 1'b1);

		// Single elements around the target, then short multisets with empty elements.
		write_target(7'd5);
		send_request(16'd5, 1'b1);
		send_request(16'd4, 1'b1);
		send_request(16'hFFFF, 1'b1);
		send_request(16'd2, 1'b0);
		send_request(16'd3, 1'b1);
		send_request(16'd0, 1'b0);
		send_request(16'd0, 1'b0);
		send_request(16'd1, 1'b1);

		// Largest table entry.
		write_target(TGT_W'(MAX_TARGET));
		send_request(16'd64, 1'b1);
		send_request(16'd63, 1'b1);
		send_request(16'hFFFF, 1'b0);
		send_request(16'hFFFF, 1'b1);

		// Target above the table clamps to the top entry.
		write_target(7'h7F);
		send_request(16'hFFFF, 1'b0);
		send_request(16'd1, 1'b1);

		// Change the target in the middle of a multiset.
		write_target(7'd2);
		send_request(16'd1, 1'b0);
		write_target(7'd3);
		send_request(16'd2, 1'b1);

		// Random multisets over three idling schemes.
		for (phase = 0; phase < 9; phase++) begin
			case (phase / 3)
				0: begin
					tx_pct = 22;
					rx_pct = 53;
				end
				1: begin
					tx_pct = 53;
					rx_pct = 22;
				end
				default: begin
					tx_pct = 0;
					rx_pct = 0;
				end
			endcase
			case (phase % 5)
				0: write_target(7'd0);
				1: write_target(TGT_W'(MAX_TARGET));
				2: write_target(7'h7F);
				3: write_target(TGT_W'($urandom_range(1, 12)));
				default: write_target(TGT_W'($urandom_range(0, 127)));
			endcase
			phase_items = 0;
			paused      = 0;
			while (phase_items < PHASE_ITEMS) begin
				mix = $urandom_range(99);
				if (mix < 65)
					len = $urandom_range(1, 5);
				else if (mix < 90)
					len = $urandom_range(6, 14);
				else
					len = $urandom_range(18, 36);
				mix = $urandom_range(2);
				for (n = 0; n < len; n++) begin
					case (mix)
						0: m = MULT_W'($urandom_range(0, 8));
						1: m = MULT_W'($urandom_range(0, 70));
						default: m = MULT_W'($urandom);
					endcase
					send_request(m, n == len - 1);
				end
				phase_items += len;
				// Hold off once per phase until all counts are back.
				if (!paused && phase_items >= PHASE_ITEMS / 2) begin
					drain_results();
					paused = 1;
				end
			end
		end

		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (tracker.errors == 0)
			$display("multiset_combination_count_core regression: pass");
		else
			$display("multiset_combination_count_core regression: fail");
		$finish;
	end

endmodule
